/* src/pooled_linked_list_manager_defines.svh */
// Assertion macros shared by the pooled linked list manager RTL.
`ifndef POOLED_LINKED_LIST_MANAGER_DEFINES_SVH
`define POOLED_LINKED_LIST_MANAGER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/pll_pkg.sv */
// Package with types, constants and helpers of the pooled linked list manager.
`default_nettype none

package pll_pkg;

   localparam int NUM_NODES = 128;
   localparam int IDX_W     = $clog2(NUM_NODES);
   localparam int LINK_W    = IDX_W + 1;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 8;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_NODES);

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_ADDED     = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_REMOVED   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic                      req_type;
      logic signed [VALUE_W-1:0] value;
   } pll_req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [COUNT_W-1:0] used_count;
      logic [COUNT_W-1:0] free_count;
   } pll_rsp_item_type;

   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [LINK_W-1:0] wr_data;
   } pll_link_req_type;

   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_data;
   } pll_value_req_type;

   function automatic logic is_node(input logic [LINK_W-1:0] link);
      return link < NULL_LINK;
   endfunction

endpackage

`default_nettype wire

/* src/pll_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module pll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/pll_link_store.sv */
// Link memory with per-entry valid bits that supply the reset chain of links.
`default_nettype none

module pll_link_store
   import pll_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pll_link_req_type  link_req,
   output      logic [LINK_W-1:0] rd_link
);

   logic [NUM_NODES-1:0] valid_ff;
   logic                 rd_valid_ff;
   logic [IDX_W-1:0]     rd_addr_ff;
   logic [LINK_W-1:0]    ram_rd_data;

   pll_ram #(
      .WIDTH (LINK_W),
      .DEPTH (NUM_NODES)
   ) u_ram (
      .clock   (clock),
      .rd_en   (link_req.rd_en),
      .rd_addr (link_req.rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (link_req.wr_en),
      .wr_addr (link_req.wr_addr),
      .wr_data (link_req.wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (link_req.wr_en) begin
         valid_ff[link_req.wr_addr] <= 1'b1;
      end
      if (link_req.rd_en) begin
         rd_valid_ff <= valid_ff[link_req.rd_addr];
         rd_addr_ff  <= link_req.rd_addr;
      end
   end

   // An entry never written still holds its reset link, the next index.
   assign rd_link = rd_valid_ff ? ram_rd_data : (LINK_W'(rd_addr_ff) + LINK_W'(1));

endmodule

`default_nettype wire

/* src/pll_walker.sv */
// Request sequencer: pops and pushes nodes and walks the used list.
`default_nettype none

module pll_walker
   import pll_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire pll_req_item_type   req_data,
   output      logic               busy,
   output      logic               rsp_valid,
   output      pll_rsp_item_type   rsp_data,
   output      pll_link_req_type   link_req,
   input  wire logic [LINK_W-1:0]  link_rd,
   output      pll_value_req_type  value_req,
   input  wire logic [VALUE_W-1:0] value_rd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_WALK,
      S_FREE
   } state_type;

   state_type          state_ff, state_in;
   logic [LINK_W-1:0]  used_head_ff, used_head_in;
   logic [LINK_W-1:0]  free_head_ff, free_head_in;
   logic [COUNT_W-1:0] free_count_ff, free_count_in;
   logic [LINK_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0]  prev_ff, prev_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   pll_rsp_item_type   rsp_ff, rsp_in;
   logic [1:0]         status;

   always_comb begin
      state_in      = state_ff;
      used_head_in  = used_head_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      status        = ST_ADDED;
      link_req      = '0;
      value_req     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in = req_data.value;
               if (req_data.req_type == OP_ADD) begin
                  if (free_count_ff == '0 || !is_node(free_head_ff)) begin
                     rsp_valid_in = 1'b1;
                     status       = ST_FULL;
                  end else begin
                     link_req.rd_en   = 1'b1;
                     link_req.rd_addr = free_head_ff[IDX_W-1:0];
                     state_in         = S_ADD;
                  end
               end else begin
                  if (!is_node(used_head_ff)) begin
                     rsp_valid_in = 1'b1;
                     status       = ST_NOT_FOUND;
                  end else begin
                     link_req.rd_en    = 1'b1;
                     link_req.rd_addr  = used_head_ff[IDX_W-1:0];
                     value_req.rd_en   = 1'b1;
                     value_req.rd_addr = used_head_ff[IDX_W-1:0];
                     cur_in            = used_head_ff;
                     prev_in           = NULL_LINK;
                     state_in          = S_WALK;
                  end
               end
            end
         end
         S_ADD: begin
            link_req.wr_en    = 1'b1;
            link_req.wr_addr  = free_head_ff[IDX_W-1:0];
            link_req.wr_data  = used_head_ff;
            value_req.wr_en   = 1'b1;
            value_req.wr_addr = free_head_ff[IDX_W-1:0];
            value_req.wr_data = value_ff;
            free_head_in      = link_rd;
            used_head_in      = free_head_ff;
            free_count_in     = free_count_ff - COUNT_W'(1);
            rsp_valid_in      = 1'b1;
            status            = ST_ADDED;
            state_in          = S_IDLE;
         end
         S_WALK: begin
            if (value_rd == value_ff) begin
               if (is_node(prev_ff)) begin
                  link_req.wr_en   = 1'b1;
                  link_req.wr_addr = prev_ff[IDX_W-1:0];
                  link_req.wr_data = link_rd;
               end else begin
                  used_head_in = link_rd;
               end
               state_in = S_FREE;
            end else if (!is_node(link_rd)) begin
               rsp_valid_in = 1'b1;
               status       = ST_NOT_FOUND;
               state_in     = S_IDLE;
            end else begin
               link_req.rd_en    = 1'b1;
               link_req.rd_addr  = link_rd[IDX_W-1:0];
               value_req.rd_en   = 1'b1;
               value_req.rd_addr = link_rd[IDX_W-1:0];
               prev_in           = cur_ff;
               cur_in            = link_rd;
            end
         end
         S_FREE: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = cur_ff[IDX_W-1:0];
            link_req.wr_data = free_head_ff;
            free_head_in     = cur_ff;
            if (free_count_ff < COUNT_W'(NUM_NODES)) begin
               free_count_in = free_count_ff + COUNT_W'(1);
            end
            rsp_valid_in = 1'b1;
            status       = ST_REMOVED;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in = rsp_ff;
      if (rsp_valid_in) begin
         rsp_in.status     = status;
         rsp_in.used_count = COUNT_W'(NUM_NODES) - free_count_in;
         rsp_in.free_count = free_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_head_ff  <= NULL_LINK;
         free_head_ff  <= '0;
         free_count_ff <= COUNT_W'(NUM_NODES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_head_ff  <= used_head_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* src/pooled_linked_list_manager.sv */
// Top level of the pooled linked list manager.
//
// A pool of 128 nodes is kept as a used list and a free list in two
// synchronous memories, one for links and one for values.
// A request transaction is accepted at a rising edge with start high and
// busy low; req_data carries the operation and the 32-bit value.
// Every request gives exactly one result transaction: rsp_valid is high for
// one cycle with status and the used and free counts on rsp_data.
// An add reads the link at the free head and then writes the node in state
// S_ADD; a full pool, or a remove on an empty list, is answered from S_IDLE.
// A remove reads one node per cycle through the link and value memories
// in state S_WALK; a match unlinks the node and returns it to the free list
// in state S_FREE, and a miss ends at the tail of the used list.
// busy falls in the cycle that shows the result, so a new request can be
// accepted while the previous result is on the ports.
// The receiver cannot stall; every result must be taken when shown.
// Synchronous reset empties the used list and chains all nodes into the
// free list at once through per-entry valid bits, with no clearing pass.
`default_nettype none
`include "pooled_linked_list_manager_defines.svh"

module pooled_linked_list_manager
   import pll_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire pll_req_item_type req_data,
   output      logic             busy,
   output      logic             rsp_valid,
   output      pll_rsp_item_type rsp_data
);

   pll_link_req_type   link_req;
   pll_value_req_type  value_req;
   logic [LINK_W-1:0]  link_rd;
   logic [VALUE_W-1:0] value_rd;

   pll_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .link_req  (link_req),
      .link_rd   (link_rd),
      .value_req (value_req),
      .value_rd  (value_rd)
   );

   pll_link_store u_link_store (
      .clock    (clock),
      .reset    (reset),
      .link_req (link_req),
      .rd_link  (link_rd)
   );

   pll_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (NUM_NODES)
   ) u_value_ram (
      .clock   (clock),
      .rd_en   (value_req.rd_en),
      .rd_addr (value_req.rd_addr),
      .rd_data (value_rd),
      .wr_en   (value_req.wr_en),
      .wr_addr (value_req.wr_addr),
      .wr_data (value_req.wr_data)
   );

   `PLL_ASSERT_SAME(a_counts_sum, clock, reset, rsp_valid, ((COUNT_W+1)'(rsp_data.used_count) + (COUNT_W+1)'(rsp_data.free_count)) == (COUNT_W+1)'(NUM_NODES), "used and free counts do not cover the pool")
   `PLL_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid, "accepted transaction neither in progress nor answered")
   `PLL_ASSERT_SAME(a_added_not_full, clock, reset, rsp_valid && rsp_data.status == ST_ADDED, rsp_data.free_count < COUNT_W'(NUM_NODES), "add reported with an untouched free list")
   `PLL_ASSERT_SAME(a_no_mem_access_idle, clock, reset, !busy && !start, !link_req.wr_en && !value_req.wr_en, "memory written while idle")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the pooled linked list manager.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import pll_pkg::*;

   localparam int RANDOM_ITEMS = 1600;

   typedef struct {
      logic             hold_for_drain;
      pll_req_item_type item;
   } pending_request_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   pll_req_item_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   pll_rsp_item_type rsp_data;

   pending_request_type  pending_requests[$];
   pll_rsp_item_type     expected_results[$];
   logic [VALUE_W-1:0]   held_values[$];
   logic [VALUE_W-1:0]   planned_values[$];

   int                   planned_count = 0;
   int                   accepted_count = 0;
   int                   error_count = 0;
   int                   burst_left = 0;
   int                   gap_left = 0;
   logic                 launch_ok;
   pending_request_type  next_request;
   pll_req_item_type     idle_junk;
   pll_rsp_item_type     seen_result;
   pll_rsp_item_type     wanted_result;

   pooled_linked_list_manager DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The used list is kept as a queue of values with the head at index 0.
   function automatic pll_rsp_item_type predict_outcome(input pll_req_item_type item);
      pll_rsp_item_type outcome;
      int               hit;
      hit = -1;
      if (item.req_type == OP_ADD) begin
         if (held_values.size() < NUM_NODES) begin
            held_values.push_front(item.value);
            outcome.status = ST_ADDED;
         end else begin
            outcome.status = ST_FULL;
         end
      end else begin
         for (int i = 0; i < held_values.size() && hit < 0; i++)
            if (held_values[i] == item.value)
               hit = i;
         if (hit >= 0) begin
            held_values.delete(hit);
            outcome.status = ST_REMOVED;
         end else begin
            outcome.status = ST_NOT_FOUND;
         end
      end
      outcome.used_count = COUNT_W'(held_values.size());
      outcome.free_count = COUNT_W'(NUM_NODES - held_values.size());
      return outcome;
   endfunction

   task automatic plan_request(input logic op, input logic [VALUE_W-1:0] v, input logic hold);
      pending_request_type entry;
      int                  hit;
      hit = -1;
      entry.hold_for_drain = hold;
      entry.item.req_type = op;
      entry.item.value = v;
      pending_requests.push_back(entry);
      planned_count++;
      if (op == OP_ADD) begin
         if (planned_values.size() < NUM_NODES)
            planned_values.push_front(v);
      end else begin
         for (int i = 0; i < planned_values.size() && hit < 0; i++)
            if (planned_values[i] == v)
               hit = i;
         if (hit >= 0)
            planned_values.delete(hit);
      end
   endtask

   function automatic logic [VALUE_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return VALUE_W'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_add_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2)
         return corner_value();
      if (pick == 2 && planned_values.size() > 0)
         return planned_values[$urandom_range(0, planned_values.size() - 1)];
      return $urandom;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_remove_value(input int hit_pct);
      if (planned_values.size() > 0 && $urandom_range(0, 99) < hit_pct)
         return planned_values[$urandom_range(0, planned_values.size() - 1)];
      if ($urandom_range(0, 3) == 0)
         return corner_value();
      return $urandom;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else if (!start || !busy) begin
         if (start) begin
            expected_results.push_back(predict_outcome(req_data));
            accepted_count++;
         end
         if (gap_left > 0) begin
            gap_left--;
            launch_ok = 1'b0;
         end else begin
            launch_ok = pending_requests.size() > 0;
         end
         if (launch_ok && pending_requests[0].hold_for_drain && expected_results.size() != 0)
            launch_ok = 1'b0;
         if (launch_ok) begin
            next_request = pending_requests.pop_front();
            start <= 1'b1;
            req_data <= next_request.item;
            if (burst_left == 0)
               burst_left = $urandom_range(1, 40);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         end else begin
            idle_junk.req_type = 1'($urandom);
            idle_junk.value = $urandom;
            start <= 1'b0;
            req_data <= idle_junk;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         seen_result = rsp_data;
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual %p",
                     $time, seen_result);
            error_count++;
         end else begin
            wanted_result = expected_results.pop_front();
            if (seen_result.status !== wanted_result.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, wanted_result.status, seen_result.status);
               error_count++;
            end
            if (seen_result.used_count !== wanted_result.used_count) begin
               $display("%0t: used_count mismatch, expected %0d, actual %0d",
                        $time, wanted_result.used_count, seen_result.used_count);
               error_count++;
            end
            if (seen_result.free_count !== wanted_result.free_count) begin
               $display("%0t: free_count mismatch, expected %0d, actual %0d",
                        $time, wanted_result.free_count, seen_result.free_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      int random_count;
      int mode;
      int seg_len;
      int extra;
      logic first_of_segment;

      // Empty list, extremes, duplicates, a freed node that held zero, reuse of freed nodes.
      plan_request(OP_REMOVE, 32'h0000_0000, 1'b0);
      plan_request(OP_REMOVE, 32'h8000_0000, 1'b0);
      plan_request(OP_ADD, 32'h8000_0000, 1'b0);
      plan_request(OP_ADD, 32'h7FFF_FFFF, 1'b0);
      plan_request(OP_ADD, 32'h0000_0000, 1'b0);
      plan_request(OP_ADD, 32'hFFFF_FFFF, 1'b0);
      plan_request(OP_ADD, 32'h0000_0001, 1'b0);
      plan_request(OP_ADD, 32'h0000_0005, 1'b0);
      plan_request(OP_ADD, 32'h0000_0005, 1'b0);
      plan_request(OP_REMOVE, 32'h0000_0005, 1'b0);
      plan_request(OP_REMOVE, 32'h8000_0000, 1'b0);
      plan_request(OP_REMOVE, 32'h0000_0000, 1'b0);
      plan_request(OP_REMOVE, 32'h0000_0000, 1'b0);
      plan_request(OP_ADD, 32'h1234_5678, 1'b0);
      plan_request(OP_REMOVE, 32'h0000_0005, 1'b0);
      plan_request(OP_REMOVE, 32'h0000_0005, 1'b0);
      plan_request(OP_REMOVE, 32'h7FFF_FFFF, 1'b0);
      plan_request(OP_REMOVE, 32'hFFFF_FFFF, 1'b0);
      plan_request(OP_REMOVE, 32'h0000_0001, 1'b0);
      plan_request(OP_REMOVE, 32'h1234_5678, 1'b0);
      plan_request(OP_REMOVE, 32'h0000_0001, 1'b0);

      random_count = 0;
      mode = 0;
      while (random_count < RANDOM_ITEMS) begin
         first_of_segment = 1'b1;
         case (mode)
            0: begin
               while (planned_values.size() < NUM_NODES) begin
                  if ($urandom_range(0, 9) == 0)
                     plan_request(OP_REMOVE, pick_remove_value(50), first_of_segment);
                  else
                     plan_request(OP_ADD, pick_add_value(), first_of_segment);
                  first_of_segment = 1'b0;
                  random_count++;
               end
               extra = $urandom_range(1, 6);
               repeat (extra) begin
                  if ($urandom_range(0, 1) == 0)
                     plan_request(OP_REMOVE, $urandom, 1'b0);
                  else
                     plan_request(OP_ADD, pick_add_value(), 1'b0);
                  random_count++;
               end
            end
            1: begin
               while (planned_values.size() > 0) begin
                  if ($urandom_range(0, 99) < 15)
                     plan_request(OP_ADD, pick_add_value(), 1'b1);
                  else
                     plan_request(OP_REMOVE, pick_remove_value(95), first_of_segment);
                  first_of_segment = 1'b0;
                  random_count++;
               end
               extra = $urandom_range(1, 3);
               repeat (extra) begin
                  plan_request(OP_REMOVE, pick_remove_value(0), 1'b0);
                  random_count++;
               end
            end
            default: begin
               seg_len = $urandom_range(20, 150);
               repeat (seg_len) begin
                  if ($urandom_range(0, 1) == 0)
                     plan_request(OP_ADD, pick_add_value(), $urandom_range(0, 49) == 0);
                  else
                     plan_request(OP_REMOVE, pick_remove_value(70),
                                  $urandom_range(0, 49) == 0);
                  random_count++;
               end
            end
         endcase
         mode = (mode == 0) ? 1 : $urandom_range(0, 2);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < planned_count)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #25ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
